FILE: src/ctc_pkg.sv
// shared types, codes and constants for the countdown timer controller
package ctc_pkg;

   localparam int CMD_DEPTH_DEF = 2;
   localparam int RSP_DEPTH_DEF = 2;

   localparam logic [5:0] TIME_MAX  = 6'd59;
   localparam logic [6:0] TIME_MOD  = 7'd60;
   localparam logic [6:0] STEP_FAST = 7'd5;
   localparam logic [6:0] STEP_SLOW = 7'd1;

   localparam logic CMD_BUTTON = 1'b0;
   localparam logic CMD_TICK   = 1'b1;

   localparam logic [3:0] BTN_IDLE       = 4'd0;
   localparam logic [3:0] BTN_LIFT       = 4'd1;
   localparam logic [3:0] BTN_PB1        = 4'd2;
   localparam logic [3:0] BTN_PB2        = 4'd3;
   localparam logic [3:0] BTN_PB31       = 4'd4;
   localparam logic [3:0] BTN_PB32       = 4'd5;
   localparam logic [3:0] BTN_PAIR_SHORT = 4'd6;
   localparam logic [3:0] BTN_PAIR_LONG  = 4'd7;
   localparam logic [3:0] BTN_ALL        = 4'd8;
   localparam logic [3:0] BTN_PB3_TAP    = 4'd9;
   localparam logic [3:0] BTN_PB3_HOLD   = 4'd10;

   typedef enum logic [2:0] {
      MODE_SET   = 3'd0,
      MODE_RUN   = 3'd1,
      MODE_PAUSE = 3'd2,
      MODE_ALARM = 3'd3,
      MODE_INFO  = 3'd4
   } mode_type;

   typedef enum logic [3:0] {
      ACT_NONE,
      ACT_RELEASED,
      ACT_SEC_UP,
      ACT_MIN_UP,
      ACT_SEC_DOWN,
      ACT_MIN_DOWN,
      ACT_START,
      ACT_ZERO,
      ACT_INFO,
      ACT_PAUSE,
      ACT_STOP,
      ACT_OTHER,
      ACT_TICK
   } act_type;

   typedef struct packed {
      act_type act;
      logic    fast;
   } cmd_type;

   typedef struct packed {
      mode_type   mode;
      logic [5:0] minutes_left;
      logic [5:0] seconds_left;
      logic       led_steady;
      logic       blink_enable;
      logic       tick_enable;
   } rsp_type;

   localparam int CMD_W = $bits(cmd_type);
   localparam int RSP_W = $bits(rsp_type);

endpackage

FILE: src/ctc_fifo.sv
// small first-in first-out queue built from registers
module ctc_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   output logic             full,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             pop,
   output logic             empty,
   output logic [WIDTH-1:0] rd_data
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rd_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({do_push, do_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

`ifndef NO_ASSERTIONS
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("queue count beyond depth");
   a_push_full_held: assert property (@(posedge clock) disable iff (reset)
      (full && !pop) |=> full)
      else $error("full queue lost an entry without a pop");
   a_ptr_match: assert property (@(posedge clock) disable iff (reset)
      (empty || full) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("pointers disagree with count");
`endif

endmodule

FILE: src/ctc_decode.sv
// front end: classifies each request into a timer action
module ctc_decode (
   input  logic            req_command,
   input  logic [3:0]      req_button,
   input  logic            req_fast,
   output ctc_pkg::cmd_type cmd
);

   import ctc_pkg::*;

   act_type btn_act;

   always_comb begin
      unique case (req_button)
         BTN_IDLE:       btn_act = ACT_NONE;
         BTN_LIFT:       btn_act = ACT_RELEASED;
         BTN_PB1:        btn_act = ACT_SEC_UP;
         BTN_PB2:        btn_act = ACT_MIN_UP;
         BTN_PB31:       btn_act = ACT_SEC_DOWN;
         BTN_PB32:       btn_act = ACT_MIN_DOWN;
         BTN_PAIR_SHORT: btn_act = ACT_START;
         BTN_PAIR_LONG:  btn_act = ACT_ZERO;
         BTN_ALL:        btn_act = ACT_INFO;
         BTN_PB3_TAP:    btn_act = ACT_PAUSE;
         BTN_PB3_HOLD:   btn_act = ACT_STOP;
         default:        btn_act = ACT_OTHER;
      endcase
   end

   always_comb begin
      cmd.fast = req_fast;
      cmd.act  = (req_command == CMD_TICK) ? ACT_TICK : btn_act;
   end

endmodule

FILE: src/ctc_exec.sv
// back end: mode state machine, time counters and led
module ctc_exec (
   input  logic             clock,
   input  logic             reset,
   input  logic             cmd_empty,
   input  ctc_pkg::cmd_type cmd,
   output logic             cmd_pop,
   input  logic             rsp_full,
   output logic             rsp_push,
   output ctc_pkg::rsp_type rsp
);

   import ctc_pkg::*;

   mode_type   mode_ff, mode_in;
   logic [5:0] minutes_ff, minutes_in;
   logic [5:0] seconds_ff, seconds_in;
   logic [5:0] seen_ff, seen_in;
   logic       led_ff, led_in;
   logic       fire;
   logic       time_zero;
   logic [6:0] step;
   logic [6:0] sec_sum;
   logic [6:0] min_sum;
   logic [5:0] sec_up;
   logic [5:0] min_up;

   assign fire      = !cmd_empty && !rsp_full;
   assign cmd_pop   = fire;
   assign rsp_push  = fire;
   assign time_zero = (minutes_ff == '0) && (seconds_ff == '0);
   assign step      = cmd.fast ? STEP_FAST : STEP_SLOW;
   assign sec_sum   = {1'b0, seconds_ff} + step;
   assign min_sum   = {1'b0, minutes_ff} + step;
   assign sec_up    = (sec_sum >= TIME_MOD) ? 6'(sec_sum - TIME_MOD) : sec_sum[5:0];
   assign min_up    = (min_sum >= TIME_MOD) ? 6'(min_sum - TIME_MOD) : min_sum[5:0];

   // next mode
   always_comb begin
      mode_in = mode_ff;
      if (fire) begin
         unique case (mode_ff)
            MODE_SET: begin
               if (cmd.act == ACT_START && !time_zero) begin
                  mode_in = MODE_RUN;
               end else if (cmd.act == ACT_INFO) begin
                  mode_in = MODE_INFO;
               end
            end
            MODE_RUN, MODE_PAUSE: begin
               if (cmd.act == ACT_PAUSE) begin
                  mode_in = (mode_ff == MODE_RUN) ? MODE_PAUSE : MODE_RUN;
               end else if (cmd.act == ACT_STOP) begin
                  mode_in = MODE_SET;
               end else if (cmd.act == ACT_TICK && mode_ff == MODE_RUN && time_zero) begin
                  mode_in = MODE_ALARM;
               end
            end
            MODE_ALARM: begin
               if (cmd.act != ACT_NONE && cmd.act != ACT_TICK) begin
                  mode_in = MODE_SET;
               end
            end
            MODE_INFO: begin
               if (cmd.act == ACT_RELEASED) begin
                  mode_in = MODE_SET;
               end
            end
            default: mode_in = MODE_SET;
         endcase
      end
   end

   // time counters
   always_comb begin
      minutes_in = minutes_ff;
      seconds_in = seconds_ff;
      if (fire) begin
         case (mode_ff)
            MODE_SET: begin
               case (cmd.act)
                  ACT_SEC_UP:   seconds_in = sec_up;
                  ACT_MIN_UP:   minutes_in = min_up;
                  ACT_SEC_DOWN: seconds_in = (seconds_ff == '0) ? TIME_MAX : seconds_ff - 1'b1;
                  ACT_MIN_DOWN: minutes_in = (minutes_ff == '0) ? TIME_MAX : minutes_ff - 1'b1;
                  ACT_ZERO: begin
                     minutes_in = '0;
                     seconds_in = '0;
                  end
                  default: ;
               endcase
            end
            MODE_RUN: begin
               if (cmd.act == ACT_STOP) begin
                  minutes_in = '0;
                  seconds_in = '0;
               end else if (cmd.act == ACT_TICK) begin
                  if (seconds_ff != '0) begin
                     seconds_in = seconds_ff - 1'b1;
                  end else if (minutes_ff != '0) begin
                     minutes_in = minutes_ff - 1'b1;
                     seconds_in = TIME_MAX;
                  end
               end
            end
            MODE_PAUSE: begin
               if (cmd.act == ACT_STOP) begin
                  minutes_in = '0;
                  seconds_in = '0;
               end
            end
            MODE_ALARM: begin
               if (cmd.act != ACT_NONE && cmd.act != ACT_TICK) begin
                  minutes_in = '0;
                  seconds_in = '0;
               end
            end
            default: ;
         endcase
      end
   end

   // led and last seen second
   always_comb begin
      led_in  = led_ff;
      seen_in = seen_ff;
      if (fire) begin
         case (mode_in)
            MODE_RUN: begin
               if (seconds_in != seen_ff) begin
                  led_in  = !led_ff;
                  seen_in = seconds_in;
               end
            end
            MODE_ALARM: led_in = (mode_ff == MODE_ALARM) ? led_ff : 1'b1;
            default:    led_in = 1'b0;
         endcase
      end
   end

   // response fields
   always_comb begin
      rsp.mode         = mode_in;
      rsp.minutes_left = minutes_in;
      rsp.seconds_left = seconds_in;
      rsp.led_steady   = led_in;
      rsp.blink_enable = (mode_in == MODE_ALARM);
      rsp.tick_enable  = (mode_in == MODE_RUN);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= MODE_SET;
         minutes_ff <= '0;
         seconds_ff <= '0;
         seen_ff    <= '0;
         led_ff     <= 1'b0;
      end else begin
         mode_ff    <= mode_in;
         minutes_ff <= minutes_in;
         seconds_ff <= seconds_in;
         seen_ff    <= seen_in;
         led_ff     <= led_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_time_range: assert property (@(posedge clock) disable iff (reset)
      (minutes_ff <= TIME_MAX) && (seconds_ff <= TIME_MAX))
      else $error("time counter out of range");
   a_alarm_led: assert property (@(posedge clock) disable iff (reset)
      (mode_ff == MODE_ALARM) |-> led_ff)
      else $error("led off during alarm");
   a_alarm_at_zero: assert property (@(posedge clock) disable iff (reset)
      (mode_ff == MODE_ALARM) |-> time_zero)
      else $error("alarm with time left");
   a_idle_hold: assert property (@(posedge clock) disable iff (reset)
      !fire |=> ($stable(mode_ff) && $stable(minutes_ff) && $stable(seconds_ff)))
      else $error("state changed without a request");
`endif

endmodule

FILE: src/countdown_timer_controller.sv
// minutes:seconds countdown timer controller top level
//
//   channel   handshake          fields
//   request   req_push/req_full  req_command, req_button, req_fast
//   response  rsp_pop/rsp_empty  rsp_mode, rsp_minutes_left, rsp_seconds_left,
//                                rsp_led_steady, rsp_blink_enable, rsp_tick_enable
//
// one request per cycle sustained while the response queue is not full; a response reaches
// the rsp ports after its request is registered in the request queue and then in the response
// queue, as the state update reads the head of the request queue and writes the response queue at the same edge
// reset is synchronous and returns the timer to set mode at 0:00 with both queues empty
// a stalled response side backs up the response queue, then the request queue,
// and only then raises req_full
module countdown_timer_controller #(
   parameter int CMD_DEPTH = ctc_pkg::CMD_DEPTH_DEF,
   parameter int RSP_DEPTH = ctc_pkg::RSP_DEPTH_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   output logic       req_full,
   input  logic       req_command,
   input  logic [3:0] req_button,
   input  logic       req_fast,
   input  logic       rsp_pop,
   output logic       rsp_empty,
   output logic [2:0] rsp_mode,
   output logic [5:0] rsp_minutes_left,
   output logic [5:0] rsp_seconds_left,
   output logic       rsp_led_steady,
   output logic       rsp_blink_enable,
   output logic       rsp_tick_enable
);

   import ctc_pkg::*;

   cmd_type cmd_in;
   cmd_type cmd_q;
   logic    cmd_empty;
   logic    cmd_pop;
   rsp_type rsp_in;
   rsp_type rsp_q;
   logic    rsp_full;
   logic    rsp_push;

   ctc_decode u_decode (
      .req_command (req_command),
      .req_button  (req_button),
      .req_fast    (req_fast),
      .cmd         (cmd_in)
   );

   ctc_fifo #(
      .WIDTH (CMD_W),
      .DEPTH (CMD_DEPTH)
   ) u_cmd_fifo (
      .clock   (clock),
      .reset   (reset),
      .push    (req_push),
      .full    (req_full),
      .wr_data (cmd_in),
      .pop     (cmd_pop),
      .empty   (cmd_empty),
      .rd_data (cmd_q)
   );

   ctc_exec u_exec (
      .clock     (clock),
      .reset     (reset),
      .cmd_empty (cmd_empty),
      .cmd       (cmd_q),
      .cmd_pop   (cmd_pop),
      .rsp_full  (rsp_full),
      .rsp_push  (rsp_push),
      .rsp       (rsp_in)
   );

   ctc_fifo #(
      .WIDTH (RSP_W),
      .DEPTH (RSP_DEPTH)
   ) u_rsp_fifo (
      .clock   (clock),
      .reset   (reset),
      .push    (rsp_push),
      .full    (rsp_full),
      .wr_data (rsp_in),
      .pop     (rsp_pop),
      .empty   (rsp_empty),
      .rd_data (rsp_q)
   );

   assign rsp_mode         = rsp_q.mode;
   assign rsp_minutes_left = rsp_q.minutes_left;
   assign rsp_seconds_left = rsp_q.seconds_left;
   assign rsp_led_steady   = rsp_q.led_steady;
   assign rsp_blink_enable = rsp_q.blink_enable;
   assign rsp_tick_enable  = rsp_q.tick_enable;

endmodule

FILE: sim/countdown_timer_checker.sv
// request and response monitor with its own timer predictor for the countdown timer controller
module countdown_timer_checker (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   input  logic       req_full,
   input  logic       req_command,
   input  logic [3:0] req_button,
   input  logic       req_fast,
   input  logic       rsp_pop,
   input  logic       rsp_empty,
   input  logic [2:0] rsp_mode,
   input  logic [5:0] rsp_minutes_left,
   input  logic [5:0] rsp_seconds_left,
   input  logic       rsp_led_steady,
   input  logic       rsp_blink_enable,
   input  logic       rsp_tick_enable,
   output int         mismatch_count,
   output int         readings_pending
);

   import ctc_pkg::*;

   mode_type   mode_q;
   logic [5:0] minutes_q;
   logic [5:0] seconds_q;
   logic [5:0] seen_seconds_q;
   logic       led_q;
   rsp_type    expected_readings[$];

   initial begin
      mismatch_count = 0;
      readings_pending = 0;
   end

   function automatic logic [5:0] count_up(input logic [5:0] value, input logic fast);
      logic [6:0] sum;
      sum = {1'b0, value} + (fast ? STEP_FAST : STEP_SLOW);
      if (sum >= TIME_MOD) begin
         sum = sum - TIME_MOD;
      end
      return sum[5:0];
   endfunction

   function automatic logic [5:0] count_down(input logic [5:0] value);
      return (value == 6'd0) ? TIME_MAX : value - 6'd1;
   endfunction

   task automatic stop_and_clear();
      mode_q    = MODE_SET;
      minutes_q = '0;
      seconds_q = '0;
      led_q     = 1'b0;
   endtask

   task automatic apply_button(input logic [3:0] button, input logic fast);
      case (mode_q)
         MODE_SET: begin
            case (button)
               BTN_PB1:        seconds_q = count_up(seconds_q, fast);
               BTN_PB2:        minutes_q = count_up(minutes_q, fast);
               BTN_PB31:       seconds_q = count_down(seconds_q);
               BTN_PB32:       minutes_q = count_down(minutes_q);
               BTN_PAIR_SHORT: begin
                  if (minutes_q != 6'd0 || seconds_q != 6'd0) begin
                     mode_q = MODE_RUN;
                  end
               end
               BTN_PAIR_LONG: begin
                  minutes_q = '0;
                  seconds_q = '0;
               end
               BTN_ALL:        mode_q = MODE_INFO;
               default: ;
            endcase
         end
         MODE_RUN, MODE_PAUSE: begin
            if (button == BTN_PB3_TAP) begin
               mode_q = (mode_q == MODE_RUN) ? MODE_PAUSE : MODE_RUN;
            end else if (button == BTN_PB3_HOLD) begin
               stop_and_clear();
            end
         end
         MODE_ALARM: begin
            if (button != BTN_IDLE) begin
               stop_and_clear();
            end
         end
         MODE_INFO: begin
            if (button == BTN_LIFT) begin
               mode_q = MODE_SET;
            end
         end
         default: ;
      endcase
   endtask

   task automatic advance_timer(input logic command, input logic [3:0] button,
                                input logic fast, output rsp_type reading);
      if (command == CMD_BUTTON) begin
         apply_button(button, fast);
      end else if (mode_q == MODE_RUN) begin
         if (seconds_q != 6'd0) begin
            seconds_q = seconds_q - 6'd1;
         end else if (minutes_q != 6'd0) begin
            minutes_q = minutes_q - 6'd1;
            seconds_q = TIME_MAX;
         end else begin
            mode_q = MODE_ALARM;
            led_q  = 1'b1;
         end
      end
      if (mode_q == MODE_RUN) begin
         if (seconds_q != seen_seconds_q) begin
            led_q          = ~led_q;
            seen_seconds_q = seconds_q;
         end
      end else if (mode_q != MODE_ALARM) begin
         led_q = 1'b0;
      end
      reading.mode         = mode_q;
      reading.minutes_left = minutes_q;
      reading.seconds_left = seconds_q;
      reading.led_steady   = led_q;
      reading.blink_enable = (mode_q == MODE_ALARM);
      reading.tick_enable  = (mode_q == MODE_RUN);
   endtask

   always @(posedge clock) begin : watch
      rsp_type want;
      rsp_type seen;
      if (reset) begin
         mode_q         = MODE_SET;
         minutes_q      = '0;
         seconds_q      = '0;
         seen_seconds_q = '0;
         led_q          = 1'b0;
         expected_readings.delete();
      end else begin
         if (rsp_pop && !rsp_empty) begin
            seen.mode         = mode_type'(rsp_mode);
            seen.minutes_left = rsp_minutes_left;
            seen.seconds_left = rsp_seconds_left;
            seen.led_steady   = rsp_led_steady;
            seen.blink_enable = rsp_blink_enable;
            seen.tick_enable  = rsp_tick_enable;
            if (expected_readings.size() == 0) begin
               if (mismatch_count < 10) begin
                  $display("%0t: unexpected response mode %0d %0d:%0d", $time,
                           seen.mode, seen.minutes_left, seen.seconds_left);
               end
               mismatch_count++;
            end else begin
               want = expected_readings.pop_front();
               if (seen.mode !== want.mode || seen.minutes_left !== want.minutes_left ||
                   seen.seconds_left !== want.seconds_left ||
                   seen.led_steady !== want.led_steady ||
                   seen.blink_enable !== want.blink_enable ||
                   seen.tick_enable !== want.tick_enable) begin
                  if (mismatch_count < 10) begin
                     $display("%0t: expected mode %0d %0d:%0d led %b blink %b tick %b", $time,
                              want.mode, want.minutes_left, want.seconds_left,
                              want.led_steady, want.blink_enable, want.tick_enable);
                     $display("%0t: actual   mode %0d %0d:%0d led %b blink %b tick %b", $time,
                              seen.mode, seen.minutes_left, seen.seconds_left,
                              seen.led_steady, seen.blink_enable, seen.tick_enable);
                  end
                  mismatch_count++;
               end
            end
         end
         if (req_push && !req_full) begin
            advance_timer(req_command, req_button, req_fast, want);
            expected_readings.push_back(want);
         end
      end
      readings_pending = expected_readings.size();
   end

endmodule

FILE: sim/tb_countdown_timer_controller.sv
// testbench top for the countdown timer controller: stimulus, idling and verdict
module tb_countdown_timer_controller;
   import ctc_pkg::*;

   localparam int ITEM_TARGET = 490;
   localparam int CALM_ITEMS  = 60;

   logic       clock = 1'b0;
   logic       reset;
   logic       req_push;
   logic       req_full;
   logic       req_command;
   logic [3:0] req_button;
   logic       req_fast;
   logic       rsp_pop;
   logic       rsp_empty;
   logic [2:0] rsp_mode;
   logic [5:0] rsp_minutes_left;
   logic [5:0] rsp_seconds_left;
   logic       rsp_led_steady;
   logic       rsp_blink_enable;
   logic       rsp_tick_enable;
   int         mismatch_count;
   int         readings_pending;
   int         sent;
   bit         calm;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   countdown_timer_controller DUT (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_command      (req_command),
      .req_button       (req_button),
      .req_fast         (req_fast),
      .rsp_pop          (rsp_pop),
      .rsp_empty        (rsp_empty),
      .rsp_mode         (rsp_mode),
      .rsp_minutes_left (rsp_minutes_left),
      .rsp_seconds_left (rsp_seconds_left),
      .rsp_led_steady   (rsp_led_steady),
      .rsp_blink_enable (rsp_blink_enable),
      .rsp_tick_enable  (rsp_tick_enable)
   );

   countdown_timer_checker checker_i (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_command      (req_command),
      .req_button       (req_button),
      .req_fast         (req_fast),
      .rsp_pop          (rsp_pop),
      .rsp_empty        (rsp_empty),
      .rsp_mode         (rsp_mode),
      .rsp_minutes_left (rsp_minutes_left),
      .rsp_seconds_left (rsp_seconds_left),
      .rsp_led_steady   (rsp_led_steady),
      .rsp_blink_enable (rsp_blink_enable),
      .rsp_tick_enable  (rsp_tick_enable),
      .mismatch_count   (mismatch_count),
      .readings_pending (readings_pending)
   );

   // called at a falling edge, returns at the falling edge after the request is taken
   task automatic send_request(input logic command, input logic [3:0] button,
                               input logic fast);
      int gap;
      gap = (!calm && $urandom_range(0, 5) == 0) ? $urandom_range(1, 16) : 0;
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_push    <= 1'b1;
      req_command <= command;
      req_button  <= button;
      req_fast    <= fast;
      do @(posedge clock); while (req_full);
      @(negedge clock);
      sent++;
   endtask

   task automatic press(input logic [3:0] button);
      send_request(CMD_BUTTON, button, 1'($urandom_range(0, 1)));
   endtask

   task automatic tick();
      send_request(CMD_TICK, 4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
   endtask

   task automatic drain_readings();
      req_push <= 1'b0;
      do @(negedge clock); while (readings_pending != 0);
   endtask

   task automatic send_noise();
      int count;
      count = $urandom_range(1, 5);
      repeat (count) begin
         send_request(1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)),
                      1'($urandom_range(0, 1)));
      end
   endtask

   task automatic run_countdown();
      int edits;
      int ticks;
      int k;
      press(BTN_PB3_HOLD);
      press(BTN_LIFT);
      press(BTN_PAIR_LONG);
      edits = $urandom_range(1, 6);
      for (k = 0; k < edits; k++) begin
         case ($urandom_range(0, 5))
            0, 1, 2: press(BTN_PB1);
            3:       press(BTN_PB31);
            4:       press(BTN_PB2);
            default: press(BTN_PB32);
         endcase
      end
      press(BTN_PAIR_SHORT);
      ticks = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 70) : $urandom_range(1, 12);
      for (k = 0; k < ticks; k++) begin
         case ($urandom_range(0, 15))
            0:       press(BTN_PB3_TAP);
            1:       press(4'($urandom_range(0, 15)));
            default: tick();
         endcase
      end
      case ($urandom_range(0, 3))
         0: press(BTN_PB3_HOLD);
         1: press(4'($urandom_range(1, 15)));
         2: begin
            press(BTN_ALL);
            press(BTN_LIFT);
         end
         default: ;
      endcase
   endtask

   initial begin : receiver
      int hold;
      hold = 0;
      rsp_pop = 1'b0;
      forever begin
         @(negedge clock);
         if (reset) begin
            rsp_pop <= 1'b0;
         end else if (hold > 0) begin
            hold--;
            rsp_pop <= 1'b0;
         end else if (!calm && $urandom_range(0, 7) == 0) begin
            hold = $urandom_range(0, 15);
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= 1'b1;
         end
      end
   end

   initial begin
      #3000000;
      $display("RESULT: ERROR");
      $finish;
   end

   initial begin : stimulus
      reset       = 1'b1;
      req_push    = 1'b0;
      req_command = CMD_BUTTON;
      req_button  = BTN_IDLE;
      req_fast    = 1'b0;
      calm        = 1'b0;
      sent        = 0;
      repeat (8) @(negedge clock);
      reset <= 1'b0;

      // ticks and a start at 0:00 are ignored, then wraps both ways
      send_request(CMD_TICK, BTN_IDLE, 1'b0);
      send_request(CMD_BUTTON, BTN_PAIR_SHORT, 1'b0);
      send_request(CMD_BUTTON, BTN_PB31, 1'b0);
      send_request(CMD_BUTTON, BTN_PB1, 1'b1);
      send_request(CMD_BUTTON, BTN_PB32, 1'b0);
      send_request(CMD_BUTTON, BTN_PB2, 1'b0);
      send_request(CMD_BUTTON, BTN_PB2, 1'b1);
      // info mode holds until release
      send_request(CMD_BUTTON, BTN_ALL, 1'b0);
      send_request(CMD_BUTTON, BTN_PB1, 1'b0);
      send_request(CMD_BUTTON, BTN_LIFT, 1'b0);
      send_request(CMD_BUTTON, BTN_PAIR_LONG, 1'b0);
      // borrow, pause, resume, long stop
      send_request(CMD_BUTTON, BTN_PB1, 1'b0);
      send_request(CMD_BUTTON, BTN_PB2, 1'b0);
      send_request(CMD_BUTTON, BTN_PAIR_SHORT, 1'b1);
      send_request(CMD_TICK, BTN_IDLE, 1'b0);
      send_request(CMD_TICK, 4'd15, 1'b1);
      send_request(CMD_BUTTON, BTN_PB3_TAP, 1'b0);
      send_request(CMD_TICK, BTN_IDLE, 1'b0);
      send_request(CMD_BUTTON, BTN_PB3_TAP, 1'b0);
      send_request(CMD_BUTTON, BTN_PB3_HOLD, 1'b0);
      // count to the alarm, none keeps it, an unused code clears it
      send_request(CMD_BUTTON, BTN_PB1, 1'b0);
      send_request(CMD_BUTTON, BTN_PAIR_SHORT, 1'b0);
      send_request(CMD_TICK, BTN_IDLE, 1'b0);
      send_request(CMD_TICK, BTN_IDLE, 1'b0);
      send_request(CMD_BUTTON, BTN_IDLE, 1'b0);
      send_request(CMD_BUTTON, 4'd13, 1'b0);
      drain_readings();

      while (sent < ITEM_TARGET) begin
         if (sent >= ITEM_TARGET - CALM_ITEMS) begin
            calm = 1'b1;
         end
         if ($urandom_range(0, 9) < 7) begin
            run_countdown();
         end else begin
            send_noise();
         end
      end

      drain_readings();
      repeat (8) @(negedge clock);
      if (mismatch_count == 0 && readings_pending == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

FILE: sim.f
src/ctc_pkg.sv
src/ctc_fifo.sv
src/ctc_decode.sv
src/ctc_exec.sv
src/countdown_timer_controller.sv
sim/countdown_timer_checker.sv
sim/tb_countdown_timer_controller.sv
